@@ hw/rtl/lapmf_pkg.sv @@
// Shared types, constants and the Laplacian kernel for the 3x3 mirror filter.
`default_nettype none
package lapmf_pkg;

  localparam int PIX_W        = 8;
  localparam int ROW_W        = 12;
  localparam int COL_W        = 10;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int SUM_W        = 12;
  localparam int PIX_MAX      = 255;

  typedef logic [PIX_W-1:0]        pix_t;
  typedef logic [ROW_W-1:0]        row_t;
  typedef logic [COL_W-1:0]        col_t;
  typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]   cfg_data_t;
  typedef logic [WIDTH_REG_W-1:0]  width_reg_t;
  typedef logic [HEIGHT_REG_W-1:0] height_reg_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  localparam cfg_idx_t REG_WIDTH  = 2'd0;
  localparam cfg_idx_t REG_HEIGHT = 2'd1;

  localparam width_reg_t  WIDTH_RESET  = 11'd512;
  localparam height_reg_t HEIGHT_RESET = 13'd512;

  // Per-pixel control captured at acceptance, consumed one stage later.
  typedef struct packed {
    pix_t pixel;
    logic emit;
    logic top_mirror;
    logic left_mirror;
    logic last_row;
    logic right_edge;
    row_t row_prev;
    row_t row_cur;
    col_t col_prev;
    col_t col_cur;
  } item_ctl_t;

  typedef struct packed {
    pix_t edge_value;
    row_t out_row;
    col_t out_col;
    logic image_done;
  } result_t;

  // Up to four results of one pixel, in delivery order.
  typedef struct packed {
    result_t [3:0] entry;
    logic [1:0]    last_idx;
  } result_set_t;

  // up + down + left + right - 4 * centre, clamped to 0..255
  function automatic pix_t lap(input pix_t up, input pix_t down, input pix_t left,
                               input pix_t right, input pix_t centre);
    sum_t s;
    pix_t r;
    s = sum_t'({4'b0000, up}) + sum_t'({4'b0000, down}) + sum_t'({4'b0000, left})
      + sum_t'({4'b0000, right}) - sum_t'({2'b00, centre, 2'b00});
    if (s < 0) begin
      r = '0;
    end else if (s > sum_t'(PIX_MAX)) begin
      r = pix_t'(PIX_MAX);
    end else begin
      r = s[PIX_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/lapmf_if.sv @@
// Handshake interfaces for the pixel, result and register-write channels.
`default_nettype none
interface lapmf_pixel_if;
  logic              valid;
  logic              ready;
  lapmf_pkg::pix_t   pixel_in;
  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface lapmf_result_if;
  logic            valid;
  logic            ready;
  lapmf_pkg::pix_t edge_value;
  lapmf_pkg::row_t out_row;
  lapmf_pkg::col_t out_col;
  logic            image_done;
  modport source (output valid, output edge_value, output out_row, output out_col,
                  output image_done, input ready);
  modport sink   (input valid, input edge_value, input out_row, input out_col,
                  input image_done, output ready);
endinterface

interface lapmf_cfg_if;
  logic                 valid;
  logic                 ready;
  lapmf_pkg::cfg_idx_t  index;
  lapmf_pkg::cfg_data_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/lapmf_line_store.sv @@
// Two row buffers: read at acceptance, upper <= old middle and middle <= pixel on writeback.
`default_nettype none
module lapmf_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  lapmf_pkg::pix_t wr_pixel,
  output lapmf_pkg::pix_t rd_upper,
  output lapmf_pkg::pix_t rd_middle
);

  lapmf_pkg::pix_t upper_mem  [DEPTH];
  lapmf_pkg::pix_t middle_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_upper  <= upper_mem[rd_addr];
      rd_middle <= middle_mem[rd_addr];
    end
  end

  // rd_middle still holds this column's old middle value until the next read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= rd_middle;
      middle_mem[wr_addr] <= wr_pixel;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/lapmf_window.sv @@
// 3x3 window shift and the Laplacian results of one pixel step with mirrored borders.
`default_nettype none
module lapmf_window (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  lapmf_pkg::item_ctl_t    ctl,
  input  lapmf_pkg::pix_t         rd_upper,
  input  lapmf_pkg::pix_t         rd_middle,
  output lapmf_pkg::result_set_t  set
);

  // Two newest columns; rows: upper, middle, newest
  lapmf_pkg::pix_t win [3][2];
  lapmf_pkg::pix_t nxt [3][3];
  lapmf_pkg::pix_t up1, up2, left1, left2;
  lapmf_pkg::pix_t res1, res2, res3, res4;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nxt[i][0] = win[i][0];
      nxt[i][1] = win[i][1];
    end
    nxt[0][2] = rd_upper;
    nxt[1][2] = rd_middle;
    nxt[2][2] = ctl.pixel;
  end

  // Mirror: row -1 reads row 1, column -1 reads column 1
  assign up1   = ctl.top_mirror  ? nxt[2][1] : nxt[0][1];
  assign up2   = ctl.top_mirror  ? nxt[2][2] : nxt[0][2];
  assign left1 = ctl.left_mirror ? nxt[1][2] : nxt[1][0];
  assign left2 = ctl.left_mirror ? nxt[2][2] : nxt[2][0];

  assign res1 = lapmf_pkg::lap(up1, nxt[2][1], left1, nxt[1][2], nxt[1][1]);
  assign res2 = lapmf_pkg::lap(nxt[1][1], nxt[1][1], left2, nxt[2][2], nxt[2][1]);
  assign res3 = lapmf_pkg::lap(up2, nxt[2][2], nxt[1][1], nxt[1][1], nxt[1][2]);
  assign res4 = lapmf_pkg::lap(nxt[1][2], nxt[1][2], nxt[2][1], nxt[2][1], nxt[2][2]);

  always_comb begin
    set.entry[0] = '{edge_value: res1, out_row: ctl.row_prev, out_col: ctl.col_prev,
                     image_done: 1'b0};
    if (ctl.last_row) begin
      set.entry[1] = '{edge_value: res2, out_row: ctl.row_cur, out_col: ctl.col_prev,
                       image_done: 1'b0};
    end else begin
      set.entry[1] = '{edge_value: res3, out_row: ctl.row_prev, out_col: ctl.col_cur,
                       image_done: 1'b0};
    end
    set.entry[2] = '{edge_value: res3, out_row: ctl.row_prev, out_col: ctl.col_cur,
                     image_done: 1'b0};
    set.entry[3] = '{edge_value: res4, out_row: ctl.row_cur, out_col: ctl.col_cur,
                     image_done: 1'b1};
    set.last_idx = {ctl.last_row & ctl.right_edge, ctl.last_row | ctl.right_edge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= '0;
        win[i][1] <= '0;
      end
    end else if (advance) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= nxt[i][1];
        win[i][1] <= nxt[i][2];
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/lapmf_result_queue.sv @@
// Holds one pixel's result set and feeds it one transaction at a time to the output register.
`default_nettype none
module lapmf_result_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  lapmf_pkg::result_set_t set_in,
  output logic                   can_load,
  lapmf_result_if.source         results
);

  logic                   rs_valid;
  logic [1:0]             rs_idx;
  lapmf_pkg::result_set_t rs_set;
  logic                   out_valid;
  lapmf_pkg::result_t     out_q;
  logic                   out_load;
  logic                   rs_done;

  assign out_load = rs_valid && (!out_valid || results.ready);
  assign rs_done  = out_load && (rs_idx == rs_set.last_idx);
  assign can_load = !rs_valid || rs_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      rs_valid  <= 1'b0;
      rs_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        rs_valid <= 1'b1;
        rs_idx   <= '0;
      end else if (rs_done) begin
        rs_valid <= 1'b0;
      end else if (out_load) begin
        rs_idx <= rs_idx + 2'd1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rs_set <= set_in;
    end
    if (out_load) begin
      out_q <= rs_set.entry[rs_idx];
    end
  end

  assign results.valid      = out_valid;
  assign results.edge_value = out_q.edge_value;
  assign results.out_row    = out_q.out_row;
  assign results.out_col    = out_q.out_col;
  assign results.image_done = out_q.image_done;

endmodule
`default_nettype wire

@@ hw/rtl/laplacian_3x3_mirror_filter.sv @@
// Path: stage 1, then the result set, then out_q. Throughput: one pixel per clock
// while the output is ready; bound by the single output register, so a pixel with two
// results (last row or right column), or the last with four, holds up the next.
// Line-store ports: one read at acceptance, one writeback per column from stage 1.
// Reset: counters and window clear, width/height go to 512, no clearing pass;
// line-store contents are undefined until written and never reach an output.
`default_nettype none
module laplacian_3x3_mirror_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic           clk,
  input  logic           rst,
  lapmf_pixel_if.sink    pixels,
  lapmf_result_if.source results,
  lapmf_cfg_if.sink      regs
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WEW = (lapmf_pkg::WIDTH_REG_W > CW + 1) ? lapmf_pkg::WIDTH_REG_W : CW + 1;
  localparam int HEW = (lapmf_pkg::HEIGHT_REG_W > RW + 1) ? lapmf_pkg::HEIGHT_REG_W : RW + 1;

  lapmf_pkg::width_reg_t  width_reg;
  lapmf_pkg::height_reg_t height_reg;
  logic [CW-1:0]          col_count;
  logic [RW-1:0]          row_count;
  logic [WEW-1:0]         w_ext, w_eff;
  logic [HEW-1:0]         h_ext, h_eff;
  logic [CW-1:0]          w_last;
  logic [RW-1:0]          h_last;
  logic                   at_right, at_bottom;
  logic                   accept;
  logic                   cfg_hit;
  logic                   s1_valid;
  logic [CW-1:0]          s1_addr;
  lapmf_pkg::item_ctl_t   s1_ctl;
  lapmf_pkg::item_ctl_t   ctl_next;
  logic                   s1_adv;
  logic                   can_load;
  lapmf_pkg::pix_t        rd_upper, rd_middle;
  lapmf_pkg::result_set_t set;

  // Effective image size, clamped to 2..MAX
  assign w_ext  = WEW'(width_reg);
  assign h_ext  = HEW'(height_reg);
  assign w_eff  = (w_ext < WEW'(2)) ? WEW'(2) :
                  (w_ext > WEW'(MAX_WIDTH)) ? WEW'(MAX_WIDTH) : w_ext;
  assign h_eff  = (h_ext < HEW'(2)) ? HEW'(2) :
                  (h_ext > HEW'(MAX_HEIGHT)) ? HEW'(MAX_HEIGHT) : h_ext;
  assign w_last = CW'(w_eff - WEW'(1));
  assign h_last = RW'(h_eff - HEW'(1));

  assign at_right  = (col_count == w_last);
  assign at_bottom = (row_count == h_last);

  assign regs.ready   = 1'b1;
  assign accept       = pixels.valid && pixels.ready;
  assign s1_adv       = s1_valid && (!s1_ctl.emit || can_load);
  assign pixels.ready = !s1_valid || s1_adv;

  always_comb begin
    cfg_hit = 1'b0;
    if (regs.valid && regs.ready) begin
      case (regs.index)
        lapmf_pkg::REG_WIDTH:  cfg_hit = 1'b1;
        lapmf_pkg::REG_HEIGHT: cfg_hit = 1'b1;
        default:               cfg_hit = 1'b0;
      endcase
    end
  end

  always_comb begin
    ctl_next.pixel       = pixels.pixel_in;
    ctl_next.emit        = (row_count != '0) && (col_count != '0);
    ctl_next.top_mirror  = (row_count == RW'(1));
    ctl_next.left_mirror = (col_count == CW'(1));
    ctl_next.last_row    = at_bottom;
    ctl_next.right_edge  = at_right;
    ctl_next.row_prev    = lapmf_pkg::row_t'(row_count - RW'(1));
    ctl_next.row_cur     = lapmf_pkg::row_t'(row_count);
    ctl_next.col_prev    = lapmf_pkg::col_t'(col_count - CW'(1));
    ctl_next.col_cur     = lapmf_pkg::col_t'(col_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= lapmf_pkg::WIDTH_RESET;
      height_reg <= lapmf_pkg::HEIGHT_RESET;
      col_count  <= '0;
      row_count  <= '0;
      s1_valid   <= 1'b0;
    end else begin
      if (regs.valid && regs.ready) begin
        case (regs.index)
          lapmf_pkg::REG_WIDTH:  width_reg  <= regs.data[lapmf_pkg::WIDTH_REG_W-1:0];
          lapmf_pkg::REG_HEIGHT: height_reg <= regs.data[lapmf_pkg::HEIGHT_REG_W-1:0];
          default: ;
        endcase
      end
      if (cfg_hit) begin
        col_count <= '0;
        row_count <= '0;
      end else if (accept) begin
        if (at_right) begin
          col_count <= '0;
          row_count <= at_bottom ? '0 : row_count + RW'(1);
        end else begin
          col_count <= col_count + CW'(1);
        end
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl  <= ctl_next;
      s1_addr <= col_count;
    end
  end

  // Consecutive pixels of one frame always hit different columns (width >= 2), and the
  // writeback lands no later than the next read, so no forwarding is needed.
  lapmf_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr   (col_count),
    .wr_en     (s1_adv),
    .wr_addr   (s1_addr),
    .wr_pixel  (s1_ctl.pixel),
    .rd_upper  (rd_upper),
    .rd_middle (rd_middle)
  );

  lapmf_window u_window (
    .clk       (clk),
    .rst       (rst),
    .advance   (s1_adv),
    .ctl       (s1_ctl),
    .rd_upper  (rd_upper),
    .rd_middle (rd_middle),
    .set       (set)
  );

  lapmf_result_queue u_result_queue (
    .clk      (clk),
    .rst      (rst),
    .load     (s1_adv && s1_ctl.emit),
    .set_in   (set),
    .can_load (can_load),
    .results  (results)
  );

endmodule
`default_nettype wire

@@ hw/rtl/lapmf_checker.sv @@
// Port-level checks for the Laplacian mirror filter, bound to the top level.
`default_nettype none
module lapmf_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            pix_ready,
  input wire logic            res_valid,
  input wire logic            res_ready,
  input wire lapmf_pkg::pix_t res_edge_value,
  input wire lapmf_pkg::row_t res_out_row,
  input wire lapmf_pkg::col_t res_out_col,
  input wire logic            res_image_done
);

  // Nothing is in flight right after reset
  a_reset_no_result: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> pix_ready)
    else $error("pixel channel not ready after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_edge_value) &&
      $stable(res_out_row) && $stable(res_out_col) && $stable(res_image_done))
    else $error("stalled result changed");

  // The final pixel sits at the bottom-right corner, never on row or column zero
  a_done_corner: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_image_done |-> (res_out_row != '0) && (res_out_col != '0))
    else $error("image end flagged off the corner");

endmodule

bind laplacian_3x3_mirror_filter lapmf_checker u_lapmf_checker (
  .clk            (clk),
  .rst            (rst),
  .pix_ready      (pixels.ready),
  .res_valid      (results.valid),
  .res_ready      (results.ready),
  .res_edge_value (results.edge_value),
  .res_out_row    (results.out_row),
  .res_out_col    (results.out_col),
  .res_image_done (results.image_done)
);
`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking testbench for the 3x3 Laplacian mirror filter: predicts and checks each result.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W         = 1024;
  localparam int MAX_H         = 4096;
  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PIXELS = 380;

  // indexes past the register list; writes to them must change nothing
  localparam lapmf_pkg::cfg_idx_t REG_SPARE_A = 2'd2;
  localparam lapmf_pkg::cfg_idx_t REG_SPARE_B = 2'd3;

  typedef enum int {FILL_NOISE, FILL_BINARY, FILL_SMOOTH} fill_t;

  typedef struct {
    lapmf_pkg::pix_t value;
    bit              drain_first;
  } pixel_job_t;

  logic clk;
  logic rst;

  lapmf_pixel_if  pix_ch();
  lapmf_result_if res_ch();
  lapmf_cfg_if    reg_ch();

  laplacian_3x3_mirror_filter #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) DUT (
    .clk(clk), .rst(rst), .pixels(pix_ch), .results(res_ch), .regs(reg_ch)
  );

  pixel_job_t          pixel_jobs[$];
  lapmf_pkg::result_t  edge_expect_q[$];

  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  int pixels_queued   = 0;
  int pixels_taken    = 0;
  int results_taken   = 0;
  int reg_writes      = 0;
  int results_pending = 0;
  int quiet_cycles    = 0;
  int mismatch_count  = 0;

  // two 2x2 frames of corners, a 3x3 bright ring around a dark centre, then the inverse
  lapmf_pkg::pix_t probe_pix[26] = '{
    8'd255, 8'd0,   8'd0,   8'd255, 8'd0,   8'd255, 8'd255, 8'd0,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0
  };

  // filter model state
  lapmf_pkg::pix_t        upper_line[MAX_W];
  lapmf_pkg::pix_t        middle_line[MAX_W];
  lapmf_pkg::pix_t        tap[3][3];  // [upper, middle, newest row][oldest .. newest column]
  int                     row_pos;
  int                     col_pos;
  lapmf_pkg::width_reg_t  width_val;
  lapmf_pkg::height_reg_t height_val;

  function automatic int clamp_size(int v, int hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic lapmf_pkg::pix_t laplace_at(int up_r, int mid_r, int dn_r, int lf_c,
                                                 int ct_c, int rt_c);
    int s;
    s = int'(tap[up_r][ct_c]) + int'(tap[dn_r][ct_c]) + int'(tap[mid_r][lf_c])
      + int'(tap[mid_r][rt_c]) - 4 * int'(tap[mid_r][ct_c]);
    if (s < 0) s = 0;
    if (s > 255) s = 255;
    return lapmf_pkg::pix_t'(s);
  endfunction

  task automatic add_expect(lapmf_pkg::pix_t v, int r, int c, bit done);
    edge_expect_q.push_back('{edge_value: v, out_row: lapmf_pkg::row_t'(r),
                              out_col: lapmf_pkg::col_t'(c), image_done: done});
  endtask

  task automatic filter_pixel(lapmf_pkg::pix_t p);
    int  w, h, x, r, top, left, i;
    bit  last_row;
    w = clamp_size(int'(width_val), MAX_W);
    h = clamp_size(int'(height_val), MAX_H);
    x = (col_pos >= MAX_W) ? 0 : col_pos;
    r = row_pos;
    for (i = 0; i < 3; i++) begin
      tap[i][0] = tap[i][1];
      tap[i][1] = tap[i][2];
    end
    tap[0][2] = upper_line[x];
    tap[1][2] = middle_line[x];
    tap[2][2] = p;
    upper_line[x]  = middle_line[x];
    middle_line[x] = p;

    if (r >= 1 && x >= 1) begin
      // mirrored border: the missing row/column reads its opposite neighbour
      top      = (r == 1) ? 2 : 0;
      left     = (x == 1) ? 2 : 0;
      last_row = (r == h - 1);
      add_expect(laplace_at(top, 1, 2, left, 1, 2), r - 1, x - 1, 1'b0);
      if (last_row) add_expect(laplace_at(1, 2, 1, left, 1, 2), r, x - 1, 1'b0);
      if (x == w - 1) begin
        add_expect(laplace_at(top, 1, 2, 1, 2, 1), r - 1, x, 1'b0);
        if (last_row) add_expect(laplace_at(1, 2, 1, 1, 2, 1), r, x, 1'b1);
      end
    end

    if (x + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = x + 1;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // pixel source
  always @(posedge clk) begin
    pixel_job_t job;
    if (rst) begin
      pix_ch.valid <= 1'b0;
    end else if (!pix_ch.valid || pix_ch.ready) begin
      if (pixel_jobs.size() != 0 && $urandom_range(99) >= send_idle_pct
          && !(pixel_jobs[0].drain_first && (pix_ch.valid || results_pending != 0))) begin
        job = pixel_jobs.pop_front();
        pix_ch.valid    <= 1'b1;
        pix_ch.pixel_in <= job.value;
      end else begin
        pix_ch.valid <= 1'b0;
      end
    end
  end

  // result sink back-pressure
  always @(posedge clk) begin
    res_ch.ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: tracks every channel, predicts and checks
  always @(posedge clk) begin
    lapmf_pkg::result_t seen;
    lapmf_pkg::result_t want;
    bit                 took;
    int                 i;
    if (rst) begin
      for (i = 0; i < 9; i++) tap[i / 3][i % 3] = '0;
      row_pos    = 0;
      col_pos    = 0;
      width_val  = lapmf_pkg::WIDTH_RESET;
      height_val = lapmf_pkg::HEIGHT_RESET;
    end else begin
      took = 1'b0;
      // a result can never stem from a pixel taken on this same edge, so check first
      if (res_ch.valid && res_ch.ready) begin
        took = 1'b1;
        results_taken <= results_taken + 1;
        seen = '{edge_value: res_ch.edge_value, out_row: res_ch.out_row,
                 out_col: res_ch.out_col, image_done: res_ch.image_done};
        if (edge_expect_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result: value %0d row %0d col %0d done %0b",
                     seen.edge_value, seen.out_row, seen.out_col, seen.image_done);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = edge_expect_q.pop_front();
          if (seen.edge_value !== want.edge_value || seen.out_row !== want.out_row
              || seen.out_col !== want.out_col || seen.image_done !== want.image_done) begin
            if (mismatch_count < 10)
              $display("mismatch: expected value %0d row %0d col %0d done %0b, got value %0d row %0d col %0d done %0b",
                       want.edge_value, want.out_row, want.out_col, want.image_done,
                       seen.edge_value, seen.out_row, seen.out_col, seen.image_done);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (reg_ch.valid && reg_ch.ready) begin
        took = 1'b1;
        reg_writes <= reg_writes + 1;
        case (reg_ch.index)
          lapmf_pkg::REG_WIDTH: begin
            width_val = lapmf_pkg::width_reg_t'(reg_ch.data);
            row_pos   = 0;
            col_pos   = 0;
          end
          lapmf_pkg::REG_HEIGHT: begin
            height_val = lapmf_pkg::height_reg_t'(reg_ch.data);
            row_pos    = 0;
            col_pos    = 0;
          end
          default: ;
        endcase
      end
      if (pix_ch.valid && pix_ch.ready) begin
        took = 1'b1;
        pixels_taken <= pixels_taken + 1;
        filter_pixel(pix_ch.pixel_in);
      end
      results_pending <= edge_expect_q.size();
      quiet_cycles    <= took ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  task automatic set_idle(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic write_reg(lapmf_pkg::cfg_idx_t idx, lapmf_pkg::cfg_data_t value);
    @(posedge clk);
    reg_ch.valid <= 1'b1;
    reg_ch.index <= idx;
    reg_ch.data  <= value;
    do @(posedge clk); while (!reg_ch.ready);
    reg_ch.valid <= 1'b0;
  endtask

  // all pixels taken, all results in, then let the pipeline drain pixels that emit nothing
  task automatic wait_idle();
    do @(posedge clk); while (pixels_taken != pixels_queued || results_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_probe(int lo, int hi, int drain_at);
    int i;
    @(negedge clk);
    for (i = lo; i <= hi; i++) begin
      pixel_jobs.push_back('{probe_pix[i], i == drain_at});
      pixels_queued++;
    end
  endtask

  task automatic queue_random(int count, fill_t fill, int drain_at);
    int level, i;
    level = $urandom_range(255);
    @(negedge clk);
    for (i = 0; i < count; i++) begin
      case (fill)
        FILL_BINARY: level = $urandom_range(1) ? 255 : 0;
        FILL_SMOOTH: begin
          level = level + int'($urandom_range(16)) - 8;
          if (level < 0) level = 0;
          if (level > 255) level = 255;
        end
        default: level = $urandom_range(255);
      endcase
      pixel_jobs.push_back('{lapmf_pkg::pix_t'(level), i == drain_at});
      pixels_queued++;
    end
  endtask

  initial begin
    int w_raw, h_raw, w_eff, h_eff, count, drain_at, choose, roll, random_pixels;
    rst             = 1'b1;
    pix_ch.valid    = 1'b0;
    pix_ch.pixel_in = '0;
    res_ch.ready    = 1'b0;
    reg_ch.valid    = 1'b0;
    reg_ch.index    = lapmf_pkg::REG_WIDTH;
    reg_ch.data     = '0;
    set_idle(24, 49);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // smallest frame: width 0 and height 1 both fall back to 2; two frames back to back
    write_reg(lapmf_pkg::REG_WIDTH, lapmf_pkg::cfg_data_t'(0));
    write_reg(lapmf_pkg::REG_HEIGHT, lapmf_pkg::cfg_data_t'(1));
    queue_probe(0, 7, -1);
    wait_idle();

    // upper data bits beyond the width field are dropped
    write_reg(lapmf_pkg::REG_WIDTH, lapmf_pkg::cfg_data_t'(13'h1803));
    write_reg(lapmf_pkg::REG_HEIGHT, lapmf_pkg::cfg_data_t'(3));
    queue_probe(8, 20, -1);
    wait_idle();
    // unused indexes must not restart the frame in progress
    write_reg(REG_SPARE_A, lapmf_pkg::cfg_data_t'(13'h1fff));
    write_reg(REG_SPARE_B, lapmf_pkg::cfg_data_t'(0));
    queue_probe(21, 25, 25);

    w_raw = 3;
    h_raw = 3;
    random_pixels = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      if (random_pixels >= 2 * RANDOM_PIXELS / 3) set_idle(0, 0);
      else if (random_pixels >= RANDOM_PIXELS / 3) set_idle(49, 24);
      wait_idle();
      choose = $urandom_range(3);
      if (choose != 1) begin
        roll = $urandom_range(9);
        if (roll == 0) w_raw = $urandom_range(1);
        else if (roll == 1) w_raw = $urandom_range(24, 13);
        else w_raw = $urandom_range(12, 2);
        write_reg(lapmf_pkg::REG_WIDTH, lapmf_pkg::cfg_data_t'(w_raw));
      end
      if (choose != 0) begin
        if ($urandom_range(7) == 0) h_raw = $urandom_range(1);
        else if (w_raw > 12) h_raw = $urandom_range(3, 2);
        else h_raw = $urandom_range(6, 2);
        write_reg(lapmf_pkg::REG_HEIGHT, lapmf_pkg::cfg_data_t'(h_raw));
      end
      w_eff = clamp_size(w_raw, MAX_W);
      h_eff = clamp_size(h_raw, MAX_H);
      count = w_eff * h_eff * $urandom_range(2, 1);
      // sometimes stop mid-frame; the next register write restarts it
      if ($urandom_range(3) == 0) count += $urandom_range(w_eff * h_eff - 1, 1);
      drain_at = ($urandom_range(2) == 0) ? w_eff * (h_eff - 1) + $urandom_range(w_eff - 1)
                                          : -1;
      queue_random(count, fill_t'($urandom_range(2)), drain_at);
      random_pixels += count;
    end

    wait_idle();
    write_reg(lapmf_pkg::REG_WIDTH, lapmf_pkg::cfg_data_t'(2));
    write_reg(lapmf_pkg::REG_HEIGHT, lapmf_pkg::cfg_data_t'(MAX_H));
    queue_random(12, FILL_BINARY, -1);

    wait_idle();
    write_reg(lapmf_pkg::REG_WIDTH, lapmf_pkg::cfg_data_t'(5));
    write_reg(lapmf_pkg::REG_HEIGHT, lapmf_pkg::cfg_data_t'(3));
    queue_random(15, FILL_SMOOTH, 12);

    wait_idle();
    repeat (12) @(posedge clk);
    $display("Run covered %0d pixels, %0d results and %0d register writes;", pixels_taken,
             results_taken, reg_writes);
    $display("frames from 2x2 to 24 wide, clamped sizes, restarts and mid-frame drains.");
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/lapmf_pkg.sv
hw/rtl/lapmf_if.sv
hw/rtl/lapmf_line_store.sv
hw/rtl/lapmf_window.sv
hw/rtl/lapmf_result_queue.sv
hw/rtl/laplacian_3x3_mirror_filter.sv
hw/rtl/lapmf_checker.sv
bench/tb_top.sv
